[rtl/ola_pkg.sv]
// Shared types, sizes and state codes for the overlap layer assigner.
`timescale 1ns / 1ps

package ola_pkg;

  localparam int MAX_LAYERS = 8;
  localparam int MAX_SLOTS  = 8;

  localparam int LYR_IDX_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int LYR_CNT_W = $clog2(MAX_LAYERS + 1);
  localparam int SLT_CNT_W = $clog2(MAX_SLOTS + 1);

  localparam int FIELD_W   = 16;
  localparam int EDGE_W    = 18;
  localparam int PLACE_W   = 3;
  localparam int USED_W    = 4;

  typedef struct packed {
    logic signed [FIELD_W-1:0] center_x;
    logic signed [FIELD_W-1:0] center_y;
    logic [FIELD_W-1:0]        rect_width;
    logic [FIELD_W-1:0]        rect_height;
  } ola_in_t;

  typedef struct packed {
    logic [PLACE_W-1:0] placed_layer;
    logic [PLACE_W-1:0] placed_slot;
    logic [USED_W-1:0]  layers_used;
    logic [USED_W-1:0]  slots_used;
    logic               overflow;
  } ola_out_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] left_edge;
    logic signed [EDGE_W-1:0] right_edge;
    logic signed [EDGE_W-1:0] bottom_edge;
    logic signed [EDGE_W-1:0] top_edge;
  } ola_rect_t;

  localparam int RECT_W = $bits(ola_rect_t);

  typedef enum logic [1:0] {
    OLA_IDLE,
    OLA_SCAN,
    OLA_DONE
  } ola_state_t;

endpackage

[rtl/ola_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module ola_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/overlap_layer_assigner.sv]
// Top level: assigns each rectangle to the layer after the last one it overlaps.
`timescale 1ns / 1ps

// Each rectangle (center and size in Q12.4) is placed in the layer after the
// last layer holding a rectangle it strictly overlaps, at that layer's first
// free column. One stored layer is read and compared per cycle: all columns
// of a layer sit side by side in per-column RAMs and are checked in parallel.
// A transaction accepted keeps busy high while every layer in use is scanned
// and while its placement is written, and out_valid pulses for one cycle in
// the cycle busy falls. The result cannot be held off: out_data is valid only in
// the out_valid cycle. When the target layer or column is past capacity,
// overflow is set and nothing is stored. The table is empty after reset.
module overlap_layer_assigner
  import ola_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ola_in_t  in_data,
  output logic     out_valid,
  output ola_out_t out_data
);

  ola_state_t state_r, state_nxt;

  ola_rect_t              rect_r, rect_nxt;
  logic [LYR_CNT_W-1:0]   rd_layer_r, rd_layer_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [LYR_IDX_W-1:0]   cmp_layer_r, cmp_layer_nxt;
  logic [LYR_CNT_W-1:0]   target_r, target_nxt;
  logic [MAX_LAYERS-1:0][MAX_SLOTS-1:0] valid_r, valid_nxt;
  logic [LYR_CNT_W-1:0]   layer_count_r, layer_count_nxt;
  logic [SLT_CNT_W-1:0]   column_count_r, column_count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ola_out_t               out_data_r, out_data_nxt;

  ola_rect_t              rd_rect [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]   lane_we;
  logic [MAX_SLOTS-1:0]   lane_hit;
  logic                   issue;
  logic                   new_layer;
  logic [MAX_SLOTS-1:0]   row_valid;
  logic [SLT_CNT_W-1:0]   free_slot;
  logic [SLT_CNT_W-1:0]   slot;
  logic                   ovf;
  logic [LYR_CNT_W-1:0]   new_layers;
  logic [SLT_CNT_W-1:0]   new_cols;
  logic signed [EDGE_W-1:0] cx2, cy2, w2, h2;

  function automatic logic rect_overlap(ola_rect_t s, ola_rect_t n);
    return !(s.left_edge >= n.right_edge || s.top_edge <= n.bottom_edge ||
             n.top_edge <= s.bottom_edge || n.left_edge >= s.right_edge);
  endfunction

  // One RAM per column, addressed by layer
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_lane
    ola_ram #(
      .WIDTH(RECT_W),
      .DEPTH(MAX_LAYERS)
    ) u_ram (
      .clk  (clk),
      .we   (lane_we[g]),
      .waddr(target_r[LYR_IDX_W-1:0]),
      .wdata(rect_r),
      .raddr(rd_layer_r[LYR_IDX_W-1:0]),
      .rdata(rd_rect[g])
    );
    assign lane_hit[g] = valid_r[cmp_layer_r][g] && rect_overlap(rd_rect[g], rect_r);
  end

  // Edges at doubled scale so halving the size is exact
  assign cx2 = {in_data.center_x[FIELD_W-1], in_data.center_x, 1'b0};
  assign cy2 = {in_data.center_y[FIELD_W-1], in_data.center_y, 1'b0};
  assign w2  = {2'b00, in_data.rect_width};
  assign h2  = {2'b00, in_data.rect_height};

  assign issue     = (state_r == OLA_SCAN) && (rd_layer_r < layer_count_r);
  assign new_layer = (target_r >= layer_count_r);
  assign row_valid = new_layer ? '0 : valid_r[target_r[LYR_IDX_W-1:0]];

  always_comb begin
    free_slot = SLT_CNT_W'(MAX_SLOTS);
    for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
      if (!row_valid[j]) begin
        free_slot = SLT_CNT_W'(j);
      end
    end
  end

  assign slot = new_layer ? '0 : free_slot;
  assign ovf  = (target_r >= LYR_CNT_W'(MAX_LAYERS)) || (slot >= SLT_CNT_W'(MAX_SLOTS));

  always_comb begin
    new_layers = layer_count_r;
    new_cols   = column_count_r;
    if (new_layer) begin
      new_layers = layer_count_r + 1'b1;
      if (column_count_r == '0) begin
        new_cols = SLT_CNT_W'(1);
      end
    end else if (slot >= column_count_r) begin
      new_cols = column_count_r + 1'b1;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_SLOTS; j++) begin
      lane_we[j] = (state_r == OLA_DONE) && !ovf && (slot == SLT_CNT_W'(j));
    end
  end

  always_comb begin
    state_nxt        = state_r;
    rect_nxt         = rect_r;
    rd_layer_nxt     = rd_layer_r;
    cmp_vld_nxt      = 1'b0;
    cmp_layer_nxt    = cmp_layer_r;
    target_nxt       = target_r;
    valid_nxt        = valid_r;
    layer_count_nxt  = layer_count_r;
    column_count_nxt = column_count_r;
    out_valid_nxt    = 1'b0;
    out_data_nxt     = out_data_r;

    unique case (state_r)
      OLA_IDLE: begin
        if (start) begin
          rect_nxt.left_edge   = cx2 - w2;
          rect_nxt.right_edge  = cx2 + w2;
          rect_nxt.bottom_edge = cy2 - h2;
          rect_nxt.top_edge    = cy2 + h2;
          rd_layer_nxt         = '0;
          target_nxt           = '0;
          state_nxt            = OLA_SCAN;
        end
      end
      OLA_SCAN: begin
        // Read layer rd_layer_r while comparing the layer read last cycle
        if (issue) begin
          rd_layer_nxt  = rd_layer_r + 1'b1;
          cmp_vld_nxt   = 1'b1;
          cmp_layer_nxt = rd_layer_r[LYR_IDX_W-1:0];
        end else begin
          state_nxt = OLA_DONE;
        end
        if (cmp_vld_r && (|lane_hit)) begin
          target_nxt = LYR_CNT_W'(cmp_layer_r) + 1'b1;
        end
      end
      OLA_DONE: begin
        out_valid_nxt = 1'b1;
        if (ovf) begin
          out_data_nxt.placed_layer = '0;
          out_data_nxt.placed_slot  = '0;
          out_data_nxt.layers_used  = USED_W'(layer_count_r);
          out_data_nxt.slots_used   = USED_W'(column_count_r);
          out_data_nxt.overflow     = 1'b1;
        end else begin
          for (int i = 0; i < MAX_LAYERS; i++) begin
            for (int j = 0; j < MAX_SLOTS; j++) begin
              if ((target_r == LYR_CNT_W'(i)) && (slot == SLT_CNT_W'(j))) begin
                valid_nxt[i][j] = 1'b1;
              end
            end
          end
          layer_count_nxt           = new_layers;
          column_count_nxt          = new_cols;
          out_data_nxt.placed_layer = PLACE_W'(target_r);
          out_data_nxt.placed_slot  = PLACE_W'(slot);
          out_data_nxt.layers_used  = USED_W'(new_layers);
          out_data_nxt.slots_used   = USED_W'(new_cols);
          out_data_nxt.overflow     = 1'b0;
        end
        state_nxt = OLA_IDLE;
      end
      default: begin
        state_nxt = OLA_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= OLA_IDLE;
      cmp_vld_r      <= 1'b0;
      valid_r        <= '0;
      layer_count_r  <= '0;
      column_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cmp_vld_r      <= cmp_vld_nxt;
      valid_r        <= valid_nxt;
      layer_count_r  <= layer_count_nxt;
      column_count_r <= column_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rect_r      <= rect_nxt;
    rd_layer_r  <= rd_layer_nxt;
    cmp_layer_r <= cmp_layer_nxt;
    target_r    <= target_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy      = (state_r != OLA_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == OLA_DONE))
    else $error("result strobe without a finished placement");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_overflow_keeps_table: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.overflow) |-> ($stable(layer_count_r) &&
      $stable(column_count_r) && $stable(valid_r)))
    else $error("table changed on overflow");

  a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (layer_count_r <= LYR_CNT_W'(MAX_LAYERS)) &&
    (column_count_r <= SLT_CNT_W'(MAX_SLOTS)))
    else $error("table dimensions past capacity");

endmodule

[tb/tb_overlap_layer_assigner.sv]
// Testbench for overlap_layer_assigner: random and directed rectangles, predicted placements.
`timescale 1ns / 1ps

module tb_overlap_layer_assigner
  import ola_pkg::*;
();

  localparam int DEPTH     = MAX_LAYERS * MAX_SLOTS;
  localparam int N_RANDOM  = 780;
  localparam int NO_IDLE_TAIL = 80;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  ola_in_t  in_data = '0;
  logic     out_valid;
  ola_out_t out_data;

  overlap_layer_assigner u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Mirror of the layer table
  int edge_l [DEPTH];
  int edge_r [DEPTH];
  int edge_b [DEPTH];
  int edge_t [DEPTH];
  bit occupied [DEPTH];
  int n_layers = 0;
  int n_cols = 0;

  ola_in_t  rect_q[$];
  ola_out_t placement_q[$];
  int rects_total = 0;
  int rects_taken = 0;
  int err_cnt = 0;
  int gap_cnt = 0;
  bit idle_on = 1'b1;

  // Place one rectangle in the mirror table and return the placement it causes.
  function automatic ola_out_t place_rect(ola_in_t rc);
    int l, r, b, t, cx2, cy2, w, h;
    int tgt, slot, nl, nc, idx;
    bit ovf;
    ola_out_t res;
    cx2 = 2 * int'($signed(rc.center_x));
    cy2 = 2 * int'($signed(rc.center_y));
    w = int'(rc.rect_width);
    h = int'(rc.rect_height);
    l = cx2 - w;
    r = cx2 + w;
    b = cy2 - h;
    t = cy2 + h;
    tgt = 0;
    slot = 0;
    for (int i = 0; i < n_layers && i < MAX_LAYERS; i++) begin
      for (int j = 0; j < MAX_SLOTS; j++) begin
        idx = i * MAX_SLOTS + j;
        if (!occupied[idx]) break;
        // strict overlap: shared edges do not count
        if (!(edge_l[idx] >= r || edge_t[idx] <= b || t <= edge_b[idx] || l >= edge_r[idx]))
        begin
          tgt = i + 1;
          break;
        end
      end
    end
    nl = n_layers;
    nc = n_cols;
    if (tgt >= n_layers) begin
      nl = n_layers + 1;
      if (nc == 0) nc = 1;
    end else begin
      while (slot < MAX_SLOTS && occupied[tgt * MAX_SLOTS + slot]) slot++;
      if (slot >= n_cols) nc = n_cols + 1;
    end
    ovf = (tgt >= MAX_LAYERS) || (slot >= MAX_SLOTS);
    res.overflow = ovf;
    if (ovf) begin
      res.placed_layer = '0;
      res.placed_slot  = '0;
    end else begin
      idx = tgt * MAX_SLOTS + slot;
      edge_l[idx] = l;
      edge_r[idx] = r;
      edge_b[idx] = b;
      edge_t[idx] = t;
      occupied[idx] = 1'b1;
      n_layers = nl;
      n_cols = nc;
      res.placed_layer = PLACE_W'(tgt);
      res.placed_slot  = PLACE_W'(slot);
    end
    res.layers_used = USED_W'(n_layers);
    res.slots_used  = USED_W'(n_cols);
    return res;
  endfunction

  task automatic add_rect(int cx, int cy, int w, int h);
    ola_in_t rc;
    rc.center_x    = 16'(cx);
    rc.center_y    = 16'(cy);
    rc.rect_width  = 16'(w);
    rc.rect_height = 16'(h);
    rect_q.push_back(rc);
  endtask

  // Mostly small rectangles on a coarse grid around a few clusters, so that
  // overlaps and shared edges are frequent; now and then any bit pattern.
  function automatic ola_in_t rand_rect();
    ola_in_t rc;
    int kind, base_x, base_y;
    kind = $urandom_range(7);
    if (kind == 0) begin
      rc.center_x    = 16'($urandom);
      rc.center_y    = 16'($urandom);
      rc.rect_width  = 16'($urandom);
      rc.rect_height = 16'($urandom);
    end else begin
      base_x = int'($urandom_range(4)) * 6000 - 12000;
      base_y = int'($urandom_range(2)) * 6000 - 6000;
      rc.center_x    = 16'(base_x + (int'($urandom_range(40)) - 20) * 8);
      rc.center_y    = 16'(base_y + (int'($urandom_range(40)) - 20) * 8);
      rc.rect_width  = 16'((kind == 1) ? $urandom_range(4000) : $urandom_range(15) * 16);
      rc.rect_height = 16'((kind == 1) ? $urandom_range(4000) : $urandom_range(15) * 16);
    end
    return rc;
  endfunction

  // Driver: one transaction per start/!busy edge, random idle bursts, drain pauses.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        placement_q.push_back(place_rect(in_data));
        rects_taken++;
        if (rects_taken % 50 == 0) idle_on = ($urandom_range(2) != 0);
      end
      if (start && busy) begin
        // hold the transaction until the block takes it
      end else if (gap_cnt != 0) begin
        gap_cnt--;
        start <= 1'b0;
      end else if (rect_q.size() == 0) begin
        start <= 1'b0;
      end else if (rects_taken % 200 == 100 && placement_q.size() != 0) begin
        // drain all outstanding placements before the next transaction
        start <= 1'b0;
      end else if (idle_on && rect_q.size() > NO_IDLE_TAIL && $urandom_range(3) == 0) begin
        gap_cnt = $urandom_range(7);
        start <= 1'b0;
      end else begin
        in_data <= rect_q.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: results cannot be stalled, so compare on every strobe.
  always @(posedge clk) begin
    ola_out_t want;
    if (rst_n && out_valid) begin
      if (placement_q.size() == 0) begin
        $error("unexpected result: %p", out_data);
        err_cnt++;
      end else begin
        want = placement_q.pop_front();
        if (out_data.placed_layer !== want.placed_layer) begin
          $error("placed_layer: expected %0d, got %0d", want.placed_layer,
                 out_data.placed_layer);
          err_cnt++;
        end
        if (out_data.placed_slot !== want.placed_slot) begin
          $error("placed_slot: expected %0d, got %0d", want.placed_slot,
                 out_data.placed_slot);
          err_cnt++;
        end
        if (out_data.layers_used !== want.layers_used) begin
          $error("layers_used: expected %0d, got %0d", want.layers_used,
                 out_data.layers_used);
          err_cnt++;
        end
        if (out_data.slots_used !== want.slots_used) begin
          $error("slots_used: expected %0d, got %0d", want.slots_used,
                 out_data.slots_used);
          err_cnt++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_data.overflow);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    // zero-size rectangles never overlap each other
    add_rect(0, 0, 0, 0);
    add_rect(0, 0, 0, 0);
    // a larger rectangle does overlap a zero-size one inside it
    add_rect(0, 0, 100, 100);
    // shared right edge, then shared top edge
    add_rect(100, 0, 100, 100);
    add_rect(0, 100, 100, 100);
    // stack up to the last layer, then one past it
    for (int k = 0; k < 7; k++) add_rect(0, 0, 4, 4);
    // field extremes
    add_rect(-32768, -32768, 65535, 65535);
    add_rect(32767, 32767, 65535, 65535);
    add_rect(32767, -32768, 0, 0);
    add_rect(-1, -1, 65535, 0);
    // fill the first layer far from everything, then run out of columns
    for (int k = 0; k < 6; k++) add_rect(-20000 + 200 * k, -20000, 16, 16);
    for (int k = 0; k < N_RANDOM; k++) rect_q.push_back(rand_rect());
    rects_total = rect_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (rects_taken != rects_total) @(posedge clk);
    while (placement_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("overlap_layer_assigner: match");
    end else begin
      $display("overlap_layer_assigner: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("overlap_layer_assigner: mismatch");
    $finish;
  end

endmodule
